// ===== rtl/core/iss_pkg.sv =====
// Shared types and constants for the indexed sequence store.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package iss_pkg;

	localparam int DEPTH     = 32;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int VAL_W     = 32;
	localparam int POS_W     = 7;
	localparam int OP_W      = 4;
	localparam int CNT_OUT_W = 7;
	localparam int STS_W     = 2;
	localparam int CMP_W     = 8;

	localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
	localparam logic [STS_W-1:0] STS_IGNORED = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL    = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_INSERT_AT  = 4'd2,
		OP_POP_FRONT  = 4'd3,
		OP_POP_BACK   = 4'd4,
		OP_REMOVE_AT  = 4'd5,
		OP_READ_FWD   = 4'd6,
		OP_READ_BWD   = 4'd7,
		OP_CLEAR      = 4'd8
	} op_t;

	// per-cycle command broadcast to every cell of the chain
	typedef enum logic [2:0] {
		ACT_HOLD,
		ACT_INS,
		ACT_DEL,
		ACT_ROT_F,
		ACT_ROT_B
	} act_t;

	typedef struct packed {
		act_t             act;
		logic [CNT_W-1:0] pos;
	} cell_ctl_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_READ
	} fsm_t;

endpackage

// ===== rtl/core/iss_cell.sv =====
// One storage cell of the shift chain: holds one value, loads from a neighbor or the load bus.
// Depends on iss_pkg.
`timescale 1ns / 1ps

module iss_cell import iss_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] idx,
	input  logic [VAL_W-1:0] left,
	input  logic [VAL_W-1:0] right,
	input  logic [VAL_W-1:0] load_val,
	output logic [VAL_W-1:0] val
);

	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] val_nxt;
	logic [CNT_W-1:0] ix;

	assign ix = CNT_W'(idx);

	always_comb begin
		val_nxt = val_q;
		case (ctl.act)
			ACT_INS: begin
				if (ix > ctl.pos) val_nxt = left;
				else if (ix == ctl.pos) val_nxt = load_val;
			end
			ACT_DEL: begin
				if (ix >= ctl.pos) val_nxt = right;
			end
			// pos is the tail slot during rotation
			ACT_ROT_F: begin
				if (ix == ctl.pos) val_nxt = load_val;
				else if (ix < ctl.pos) val_nxt = right;
			end
			ACT_ROT_B: begin
				if (ix == '0) val_nxt = load_val;
				else if (ix <= ctl.pos) val_nxt = left;
			end
			default: val_nxt = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

	assign val = val_q;

endmodule

// ===== rtl/core/iss_chain.sv =====
// Row of DEPTH cells linked to their neighbors, with head and tail taps.
// Depends on iss_pkg and iss_cell.
`timescale 1ns / 1ps

module iss_chain import iss_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [VAL_W-1:0] load_val,
	input  logic [IDX_W-1:0] tail_idx,
	output logic [VAL_W-1:0] head,
	output logic [VAL_W-1:0] tail
);

	logic [VAL_W-1:0] vals [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] lft;
		logic [VAL_W-1:0] rgt;

		if (i == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid_l
			assign lft = vals[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_mid_r
			assign rgt = vals[i+1];
		end

		iss_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.idx      (IDX_W'(i)),
			.left     (lft),
			.right    (rgt),
			.load_val (load_val),
			.val      (vals[i])
		);
	end

	assign head = vals[0];
	assign tail = vals[tail_idx];

endmodule

// ===== rtl/core/indexed_sequence_store.sv =====
// Indexed sequence store: a bounded ordered list of signed 32-bit values held in a shift chain.
// Each insert, remove, push, pop or clear yields its result word in the cycle after the accepted word,
// since the chain updates all its cells at once. During a readout the chain rotates one slot per
// cycle while the output is free (head or tail streaming out), starting after the accepting cycle,
// and the chain ends up in its original order. New words are not taken while a readout runs.
// Depends on iss_pkg and iss_chain.
`timescale 1ns / 1ps

module indexed_sequence_store import iss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // item_value[31:0], position[38:32], zero[39]
	input  logic [3:0]  s_tuser,   // operation[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // read_value[31:0], count[38:32], status[40:39], zero[47:41]
	output logic        m_tuser,   // element_valid
	output logic        m_tlast
);

	fsm_t             state_q, state_nxt;
	logic [CNT_W-1:0] count_q, count_nxt;
	logic [CNT_W-1:0] rd_idx_q;
	logic             dir_bwd_q;
	logic             m_valid_q;
	logic [VAL_W-1:0] out_val_q;
	logic             out_ev_q;
	logic             out_last_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [STS_W-1:0] out_sts_q;

	logic             in_acc;
	logic             out_free;
	logic             rd_active;
	op_t              op;
	logic [VAL_W-1:0] in_val;
	logic [POS_W-1:0] in_pos;
	logic [CMP_W-1:0] pos_u, cnt_u;
	logic             pos_neg;
	logic             is_full, is_empty;
	logic [CNT_W-1:0] ins_p;
	logic             start_read;
	logic             rd_last;

	cell_ctl_t        ctl;
	logic [VAL_W-1:0] load_val;
	logic [VAL_W-1:0] head, tail;
	logic [IDX_W-1:0] tail_idx;

	logic             out_ld;
	logic [VAL_W-1:0] out_val_d;
	logic             out_ev_d;
	logic             out_last_d;
	logic [STS_W-1:0] out_sts_d;

	assign op       = op_t'(s_tuser);
	assign in_val   = s_tdata[31:0];
	assign in_pos   = s_tdata[38:32];
	assign pos_neg  = in_pos[POS_W-1];
	assign pos_u    = CMP_W'(in_pos[POS_W-2:0]);
	assign cnt_u    = CMP_W'(count_q);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign tail_idx = IDX_W'(count_q - 1'b1);
	assign rd_last  = (CNT_W'(rd_idx_q + 1'b1) == count_q);
	assign out_free = !m_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;

	// insert slot, clamped to the ends
	always_comb begin
		if (pos_neg || pos_u == '0) ins_p = '0;
		else if (pos_u >= cnt_u) ins_p = count_q;
		else ins_p = CNT_W'(pos_u);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			FSM_IDLE: if (start_read) state_nxt = FSM_READ;
			FSM_READ: if (out_free && rd_last) state_nxt = FSM_IDLE;
			default:  state_nxt = FSM_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		s_tready  = 1'b0;
		rd_active = 1'b0;
		unique case (state_q)
			FSM_IDLE: s_tready  = out_free;
			FSM_READ: rd_active = out_free;
			default: begin
				s_tready  = 1'b0;
				rd_active = 1'b0;
			end
		endcase
	end

	// command decode and result word
	always_comb begin
		ctl.act    = ACT_HOLD;
		ctl.pos    = '0;
		load_val   = in_val;
		count_nxt  = count_q;
		start_read = 1'b0;
		out_ld     = 1'b0;
		out_val_d  = '0;
		out_ev_d   = 1'b0;
		out_last_d = 1'b1;
		out_sts_d  = STS_DONE;

		if (rd_active) begin
			out_ld     = 1'b1;
			out_val_d  = dir_bwd_q ? tail : head;
			out_ev_d   = 1'b1;
			out_last_d = rd_last;
			ctl.act    = dir_bwd_q ? ACT_ROT_B : ACT_ROT_F;
			ctl.pos    = count_q - 1'b1;
			load_val   = dir_bwd_q ? tail : head;
		end else if (in_acc) begin
			out_ld = 1'b1;
			unique case (op) inside
				OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
					if (is_full) begin
						out_sts_d = STS_FULL;
					end else begin
						ctl.act   = ACT_INS;
						ctl.pos   = (op == OP_PUSH_FRONT) ? '0 :
						            (op == OP_PUSH_BACK)  ? count_q : ins_p;
						count_nxt = count_q + 1'b1;
					end
				end
				OP_POP_FRONT: begin
					if (is_empty) begin
						out_sts_d = STS_IGNORED;
					end else begin
						ctl.act   = ACT_DEL;
						count_nxt = count_q - 1'b1;
					end
				end
				OP_POP_BACK: begin
					if (is_empty) out_sts_d = STS_IGNORED;
					else count_nxt = count_q - 1'b1;
				end
				OP_REMOVE_AT: begin
					if (pos_neg || pos_u >= cnt_u) begin
						out_sts_d = STS_IGNORED;
					end else begin
						ctl.act   = ACT_DEL;
						ctl.pos   = CNT_W'(pos_u);
						count_nxt = count_q - 1'b1;
					end
				end
				OP_READ_FWD, OP_READ_BWD: begin
					// empty store answers with one blank word
					if (!is_empty) begin
						start_read = 1'b1;
						out_ld     = 1'b0;
					end
				end
				OP_CLEAR: count_nxt = '0;
				default:  out_sts_d = STS_IGNORED;
			endcase
		end
	end

	iss_chain u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.load_val (load_val),
		.tail_idx (tail_idx),
		.head     (head),
		.tail     (tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			count_q   <= '0;
			rd_idx_q  <= '0;
			dir_bwd_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (start_read) begin
				rd_idx_q  <= '0;
				dir_bwd_q <= (op == OP_READ_BWD);
			end else if (rd_active) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (out_ld) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_val_q  <= out_val_d;
			out_ev_q   <= out_ev_d;
			out_last_q <= out_last_d;
			out_cnt_q  <= count_nxt;
			out_sts_q  <= out_sts_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, out_sts_q, CNT_OUT_W'(out_cnt_q), out_val_q};
	assign m_tuser  = out_ev_q;
	assign m_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count beyond depth");

	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_READ |-> !s_tready)
		else $error("input taken during readout");

	a_read_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_READ && out_free && rd_last) |=> state_q == FSM_IDLE)
		else $error("readout did not end after last element");

	a_read_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_READ |=> $stable(count_q))
		else $error("count changed during readout");

	a_elem_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_ev_q) |-> out_sts_q == STS_DONE)
		else $error("element word with non-done status");

endmodule
